// ===== hdl/loa_pkg.sv =====
// ----------------------------------------------------------------------------
// loa_pkg
// shared types for the lifetime offset allocator: result codes, controller
// states, and the command and status groups between controller and datapath
// ----------------------------------------------------------------------------
package loa_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CHECK    = 7'b0000010,
    S_ALIGN    = 7'b0000100,
    S_END      = 7'b0001000,
    S_SCAN_REQ = 7'b0010000,
    S_SCAN_CMP = 7'b0100000,
    S_COMMIT   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic    load;
    logic    init_fixed;
    logic    init_search;
    logic    align;
    logic    end_chk;
    logic    scan_start;
    logic    scan_step;
    logic    restart;
    logic    commit;
    logic    finish;
    status_e fin_status;
  } cmd_t;

  typedef struct packed {
    logic size_zero;
    logic req_bad;
    logic fixed;
    logic fix_misal;
    logic fix_over;
    logic ovf_align;
    logic ovf_end;
    logic count_zero;
    logic clash;
    logic scan_last;
    logic full;
  } stat_t;

endpackage

// ===== hdl/loa_dp.sv =====
// ----------------------------------------------------------------------------
// loa_dp
// datapath: request registers, interval table, candidate alignment and end
// checks, one-entry-per-cycle clash compare, high-water mark and result
// ----------------------------------------------------------------------------
module loa_dp #(
  parameter int MAX_INTERVALS = 64,
  parameter int OFFSET_BITS   = 32,
  parameter int STAGE_BITS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  loa_pkg::cmd_t         cmd_i,
  output loa_pkg::stat_t        stat_o,
  input  logic                  start_new_plan_i,
  input  logic [31:0]           size_bytes_i,
  input  logic [31:0]           align_bytes_i,
  input  logic [15:0]           first_stage_i,
  input  logic [15:0]           last_stage_i,
  input  logic                  use_fixed_offset_i,
  input  logic [31:0]           fixed_offset_i,
  output logic                  done_o,
  output loa_pkg::status_e      status_o,
  output logic [31:0]           placed_offset_o,
  output logic [31:0]           peak_bytes_o
);

  localparam int SW = (STAGE_BITS < 16) ? STAGE_BITS : 16;
  localparam int OB = OFFSET_BITS;
  localparam int AW = ((OB > 32) ? OB : 32) + 1;
  localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam logic [AW-1:0] OFF_MAX = {{(AW-OB){1'b0}}, {OB{1'b1}}};
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

  logic [SW-1:0] mem_first [MAX_INTERVALS];
  logic [SW-1:0] mem_last  [MAX_INTERVALS];
  logic [OB-1:0] mem_off   [MAX_INTERVALS];
  logic [OB-1:0] mem_end   [MAX_INTERVALS];

  logic [SW-1:0] rd_first_q, rd_last_q;
  logic [OB-1:0] rd_off_q, rd_end_q;

  logic [31:0]   size_q, align_q, fixed_off_q;
  logic [SW-1:0] first_q, last_q;
  logic          fixed_q;
  logic [OB-1:0] off_q, end_q, search_q, hwm_q;
  logic [CW-1:0] count_q, idx_q;

  logic              done_q;
  loa_pkg::status_e  status_q;
  logic [31:0]       offset_q, peak_q;

  logic [AW-1:0] size_w, align_m1, fixed_w, search_w, off_w, aligned_w, end_w;
  logic [AW-1:0] off_out_w, hwm_w, end_q_w;
  logic [CW-1:0] idx_next;
  logic [IW-1:0] rd_addr, wr_addr;
  logic          live, bytes, new_peak;

  always_comb begin
    size_w    = AW'(size_q);
    align_m1  = AW'(align_q) - AW'(1);
    fixed_w   = AW'(fixed_off_q);
    search_w  = AW'(search_q);
    off_w     = AW'(off_q);
    aligned_w = (search_w + align_m1) & ~align_m1;
    end_w     = off_w + size_w;
    idx_next  = idx_q + CW'(1);
    rd_addr   = cmd_i.scan_start ? '0 : idx_next[IW-1:0];
    wr_addr   = count_q[IW-1:0];
    live      = (rd_first_q <= last_q) && (first_q <= rd_last_q);
    bytes     = (rd_off_q < end_q) && (off_q < rd_end_q);
    new_peak  = end_q > hwm_q;
    off_out_w = cmd_i.commit ? off_w : '0;
    end_q_w   = AW'(end_q);
    hwm_w     = (cmd_i.commit && new_peak) ? end_q_w : AW'(hwm_q);
  end

  always_comb begin
    stat_o.size_zero  = size_q == 32'd0;
    stat_o.req_bad    = (last_q < first_q) || (align_q == 32'd0) ||
                        ((align_q & (align_q - 32'd1)) != 32'd0);
    stat_o.fixed      = fixed_q;
    stat_o.fix_misal  = (fixed_off_q & (align_q - 32'd1)) != 32'd0;
    stat_o.fix_over   = fixed_w > OFF_MAX;
    stat_o.ovf_align  = (search_w > (OFF_MAX - align_m1)) || (align_m1 > OFF_MAX);
    stat_o.ovf_end    = size_w > (OFF_MAX - off_w);
    stat_o.count_zero = count_q == '0;
    stat_o.clash      = live && bytes;
    stat_o.scan_last  = idx_next == count_q;
    stat_o.full       = count_q >= MAX_CNT;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      mem_first[wr_addr] <= first_q;
      mem_last[wr_addr]  <= last_q;
      mem_off[wr_addr]   <= off_q;
      mem_end[wr_addr]   <= end_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_first_q <= mem_first[rd_addr];
    rd_last_q  <= mem_last[rd_addr];
    rd_off_q   <= mem_off[rd_addr];
    rd_end_q   <= mem_end[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      size_q      <= size_bytes_i;
      align_q     <= align_bytes_i;
      first_q     <= first_stage_i[SW-1:0];
      last_q      <= last_stage_i[SW-1:0];
      fixed_q     <= use_fixed_offset_i;
      fixed_off_q <= fixed_offset_i;
    end
    if (cmd_i.init_fixed) begin
      off_q <= fixed_w[OB-1:0];
    end
    if (cmd_i.align) begin
      off_q <= aligned_w[OB-1:0];
    end
    if (cmd_i.init_search) begin
      search_q <= '0;
    end
    if (cmd_i.restart) begin
      search_q <= rd_end_q;
    end
    if (cmd_i.end_chk) begin
      end_q <= end_w[OB-1:0];
    end
    if (cmd_i.finish) begin
      status_q <= cmd_i.fin_status;
      offset_q <= off_out_w[31:0];
      peak_q   <= hwm_w[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hwm_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= cmd_i.finish;
      if (cmd_i.load && start_new_plan_i) begin
        count_q <= '0;
        hwm_q   <= '0;
      end
      if (cmd_i.commit) begin
        count_q <= count_q + CW'(1);
        if (new_peak) begin
          hwm_q <= end_q;
        end
      end
      if (cmd_i.scan_start) begin
        idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_next;
      end
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign placed_offset_o = offset_q;
  assign peak_bytes_o    = peak_q;

endmodule

// ===== hdl/loa_ctrl.sv =====
// ----------------------------------------------------------------------------
// loa_ctrl
// controller: sequences validation, alignment, end check, table scan with
// first-fit restart, and commit of one request
// ----------------------------------------------------------------------------
module loa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  loa_pkg::stat_t stat_i,
  output loa_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  loa_pkg::state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.fin_status = loa_pkg::ST_OK;
    unique case (state_q)
      loa_pkg::S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = loa_pkg::S_CHECK;
        end
      end
      loa_pkg::S_CHECK: begin
        if (stat_i.size_zero) begin
          cmd_o.finish = 1'b1;
          state_d      = loa_pkg::S_IDLE;
        end else if (stat_i.req_bad || (stat_i.fixed && stat_i.fix_misal)) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = loa_pkg::ST_INVALID;
          state_d          = loa_pkg::S_IDLE;
        end else if (stat_i.fixed && stat_i.fix_over) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = loa_pkg::ST_OVERFLOW;
          state_d          = loa_pkg::S_IDLE;
        end else if (stat_i.fixed) begin
          cmd_o.init_fixed = 1'b1;
          state_d          = loa_pkg::S_END;
        end else begin
          cmd_o.init_search = 1'b1;
          state_d           = loa_pkg::S_ALIGN;
        end
      end
      loa_pkg::S_ALIGN: begin
        if (stat_i.ovf_align) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = loa_pkg::ST_OVERFLOW;
          state_d          = loa_pkg::S_IDLE;
        end else begin
          cmd_o.align = 1'b1;
          state_d     = loa_pkg::S_END;
        end
      end
      loa_pkg::S_END: begin
        if (stat_i.ovf_end) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = loa_pkg::ST_OVERFLOW;
          state_d          = loa_pkg::S_IDLE;
        end else begin
          cmd_o.end_chk = 1'b1;
          state_d       = stat_i.count_zero ? loa_pkg::S_COMMIT : loa_pkg::S_SCAN_REQ;
        end
      end
      loa_pkg::S_SCAN_REQ: begin
        cmd_o.scan_start = 1'b1;
        state_d          = loa_pkg::S_SCAN_CMP;
      end
      loa_pkg::S_SCAN_CMP: begin
        if (stat_i.clash && stat_i.fixed) begin
          cmd_o.finish     = 1'b1;
          cmd_o.fin_status = loa_pkg::ST_INVALID;
          state_d          = loa_pkg::S_IDLE;
        end else if (stat_i.clash) begin
          cmd_o.restart = 1'b1;
          state_d       = loa_pkg::S_ALIGN;
        end else if (stat_i.scan_last) begin
          state_d = loa_pkg::S_COMMIT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      loa_pkg::S_COMMIT: begin
        cmd_o.finish = 1'b1;
        state_d      = loa_pkg::S_IDLE;
        if (stat_i.full) begin
          cmd_o.fin_status = loa_pkg::ST_FULL;
        end else begin
          cmd_o.commit = 1'b1;
        end
      end
      default: begin
        state_d = loa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= loa_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != loa_pkg::S_IDLE;

endmodule

// ===== hdl/lifetime_offset_allocator.sv =====
// ----------------------------------------------------------------------------
// lifetime_offset_allocator
// first-fit workspace offset allocator over buffer lifetimes
//
// a request transaction is taken when start is high and busy is low; busy
// stays high until the result is produced. the result appears on status_o,
// placed_offset_o and peak_bytes_o for one cycle with done_o high, in the
// cycle busy drops, and must be taken then: the receiver cannot stall.
// zero-size requests and requests rejected at the first check finish from
// the check state. a fixed placement runs the check, the end check, a scan
// of the stored intervals (skipped with an empty table) and the commit. a
// search adds an alignment step before the end check; each collision at a
// table entry restarts the candidate at that entry's end, realigns, checks
// the end again and rescans the table from its first entry. the next
// transaction can be taken in the done_o cycle. the interval table is a
// single-port-read memory scanned one entry per cycle. reset empties the
// table and clears the high-water mark at once; table contents are not
// cleared.
// ----------------------------------------------------------------------------
module lifetime_offset_allocator #(
  parameter int MAX_INTERVALS = 64,
  parameter int OFFSET_BITS   = 32,
  parameter int STAGE_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        start_new_plan_i,
  input  logic [31:0] size_bytes_i,
  input  logic [31:0] align_bytes_i,
  input  logic [15:0] first_stage_i,
  input  logic [15:0] last_stage_i,
  input  logic        use_fixed_offset_i,
  input  logic [31:0] fixed_offset_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] placed_offset_o,
  output logic [31:0] peak_bytes_o
);

  loa_pkg::cmd_t    cmd;
  loa_pkg::stat_t   stat;
  loa_pkg::status_e status;
  logic             accept;

  assign accept = start && !busy;

  loa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  loa_dp #(
    .MAX_INTERVALS (MAX_INTERVALS),
    .OFFSET_BITS   (OFFSET_BITS),
    .STAGE_BITS    (STAGE_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .start_new_plan_i   (start_new_plan_i),
    .size_bytes_i       (size_bytes_i),
    .align_bytes_i      (align_bytes_i),
    .first_stage_i      (first_stage_i),
    .last_stage_i       (last_stage_i),
    .use_fixed_offset_i (use_fixed_offset_i),
    .fixed_offset_i     (fixed_offset_i),
    .done_o             (done_o),
    .status_o           (status),
    .placed_offset_o    (placed_offset_o),
    .peak_bytes_o       (peak_bytes_o)
  );

  assign status_o = status;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("busy not raised after request");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result while still busy");

  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");

  a_err_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status != loa_pkg::ST_OK) |-> (placed_offset_o == 32'd0))
    else $error("nonzero offset on error");

endmodule
